FILE: design/assert_macros.svh
// Assertion macros used by the command queue of the control endpoint RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define USBEP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("usbep assertion failed");
// condition that must never hold outside reset
`define USBEP_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("usbep forbidden condition seen");
`else
`define USBEP_ASSERT(lbl, clk, rst, prop)
`define USBEP_NEVER(lbl, clk, rst, cond)
`endif
`endif

FILE: design/usbep_pkg.sv
// Types, codes and constants of the USB control endpoint engine
package usbep_pkg;

  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    OP_SETUP = 2'd0,
    OP_IN    = 2'd1,
    OP_OUT   = 2'd2,
    OP_RESET = 2'd3
  } opcode_t;

  localparam logic [1:0] HS_ACK   = 2'd0;
  localparam logic [1:0] HS_NAK   = 2'd1;
  localparam logic [1:0] HS_STALL = 2'd2;

  localparam logic [3:0] SRC_NONE    = 4'd0;
  localparam logic [3:0] SRC_DEVICE  = 4'd1;
  localparam logic [3:0] SRC_CONFIG  = 4'd2;
  localparam logic [3:0] SRC_LANG    = 4'd3;
  localparam logic [3:0] SRC_MAKER   = 4'd4;
  localparam logic [3:0] SRC_PRODUCT = 4'd5;
  localparam logic [3:0] SRC_SERIAL  = 4'd6;
  localparam logic [3:0] SRC_CFGBYTE = 4'd7;
  localparam logic [3:0] SRC_ZEROS   = 4'd8;

  localparam logic [1:0] EV_NONE       = 2'd0;
  localparam logic [1:0] EV_GET_CODING = 2'd1;
  localparam logic [1:0] EV_SET_LINES  = 2'd2;
  localparam logic [1:0] EV_CODING_DAT = 2'd3;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_HALT  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [7:0] RC_GET_STATUS  = 8'h00;
  localparam logic [7:0] RC_CLR_FEATURE = 8'h01;
  localparam logic [7:0] RC_SET_FEATURE = 8'h03;
  localparam logic [7:0] RC_SET_ADDRESS = 8'h05;
  localparam logic [7:0] RC_GET_DESC    = 8'h06;
  localparam logic [7:0] RC_GET_CONFIG  = 8'h08;
  localparam logic [7:0] RC_SET_CONFIG  = 8'h09;
  localparam logic [7:0] RC_GET_IFACE   = 8'h0A;
  localparam logic [7:0] RC_SET_IFACE   = 8'h0B;
  localparam logic [7:0] RC_SEND_ENCAP  = 8'h20;
  localparam logic [7:0] RC_GET_CODING  = 8'h21;
  localparam logic [7:0] RC_SET_LINES   = 8'h22;
  localparam logic [7:0] NO_REQUEST     = 8'hFF;

  localparam logic [7:0] SERIAL_LEN  = 8'd22;
  localparam logic [6:0] SETUP_BYTES = 7'd8;
  localparam logic [6:0] MAX_CHUNK   = 7'd64;

  // register indexes on the configuration port
  localparam logic [2:0] REG_DEVICE_LEN  = 3'd0;
  localparam logic [2:0] REG_CONFIG_LEN  = 3'd1;
  localparam logic [2:0] REG_LANG_LEN    = 3'd2;
  localparam logic [2:0] REG_MAKER_LEN   = 3'd3;
  localparam logic [2:0] REG_PRODUCT_LEN = 3'd4;
  localparam logic [2:0] REG_WAKEUP      = 3'd5;
  localparam logic [2:0] REG_EP0_SIZE    = 3'd6;
  localparam logic [2:0] REG_CODING_LEN  = 3'd7;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [6:0]  received_length;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] length_word;
    logic        toggle_matched;
  } req_t;

  typedef struct packed {
    logic [1:0] in_handshake;
    logic [1:0] out_handshake;
    logic       data_toggle;
    logic [6:0] send_length;
    logic [3:0] data_source;
    logic [7:0] source_offset;
    logic [6:0] device_address;
    logic [7:0] config_value;
    logic [1:0] class_event;
    logic [3:0] endpoint_select;
    logic [1:0] endpoint_action;
    logic       sleep_request;
  } rsp_t;

  typedef struct packed {
    logic [7:0] device_desc_length;
    logic [7:0] config_desc_length;
    logic [7:0] language_desc_length;
    logic [7:0] maker_desc_length;
    logic [7:0] product_desc_length;
    logic       wakeup_capable;
    logic [6:0] ep0_packet_size;
    logic [6:0] line_coding_length;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    opcode_t     op;
    logic        len_ok;
    logic        stall;
    logic [7:0]  pending;
    logic [15:0] remaining;
    logic        desc_wr;
    logic [3:0]  src;
    logic [7:0]  offset;
    logic        cfg_wr;
    logic [7:0]  cfg_val;
    logic [6:0]  pkt_len;
    logic [3:0]  pkt_src;
    logic [1:0]  ev_class;
    logic [3:0]  ev_sel;
    logic [1:0]  ev_act;
    logic        ev_sleep;
    logic        toggle_matched;
  } cmd_t;

  // chunk size, sizes above 64 act as 64
  function automatic logic [6:0] chunk_size(input logic [6:0] size);
    chunk_size = (size > MAX_CHUNK) ? MAX_CHUNK : size;
  endfunction

endpackage

FILE: design/usbep_front.sv
// Front part: accepts requests and decodes setup packets into commands
module usbep_front import usbep_pkg::*; (
  input  cfg_t cfg,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic push,
  output cmd_t push_cmd,
  input  logic full
);

  // endpoint address to select code, zero when not endpoint 1..4
  function automatic logic [3:0] ep_select(input logic [15:0] addr);
    logic [6:0] n;
    n = addr[6:0];
    if (addr[15:8] != 8'd0 || n < 7'd1 || n > 7'd4) ep_select = 4'd0;
    else if (addr[7]) ep_select = n[3:0] + 4'd4;
    else ep_select = n[3:0];
  endfunction

  logic [6:0] ep;
  logic [7:0] dlen, total, len;
  logic [3:0] src, sel;
  cmd_t       cmd;

  assign req_stall = full;
  assign push      = req_valid & ~full;
  assign push_cmd  = cmd;
  assign ep        = chunk_size(cfg.ep0_packet_size);

  // setup decode
  always_comb begin
    cmd = '0;
    dlen = 8'd0;
    total = 8'd0;
    len = 8'd0;
    src = SRC_NONE;
    sel = 4'd0;
    cmd.op = opcode_t'(req.opcode);
    cmd.toggle_matched = req.toggle_matched;
    cmd.len_ok = (req.received_length == SETUP_BYTES);
    cmd.remaining = req.length_word;
    cmd.pending = req.request_code;
    if (!cmd.len_ok) begin
      cmd.stall = 1'b1;
    end else if (req.request_type[6:5] == 2'b01) begin
      // class requests
      case (req.request_code)
        RC_GET_CODING: begin
          len = {1'b0, cfg.line_coding_length};
          cmd.ev_class = EV_GET_CODING;
        end
        RC_SET_LINES:  cmd.ev_class = EV_SET_LINES;
        RC_SEND_ENCAP: ;
        default:       cmd.stall = 1'b1;
      endcase
    end else if (req.request_type[6:5] != 2'b00) begin
      cmd.stall = 1'b1;
    end else begin
      unique case (req.request_code)
        RC_GET_DESC: begin
          case (req.value_word[15:8])
            8'd1: begin src = SRC_DEVICE; dlen = cfg.device_desc_length; end
            8'd2: begin src = SRC_CONFIG; dlen = cfg.config_desc_length; end
            8'd3: begin
              case (req.value_word[7:0])
                8'd0: begin src = SRC_LANG; dlen = cfg.language_desc_length; end
                8'd1: begin src = SRC_MAKER; dlen = cfg.maker_desc_length; end
                8'd2: begin src = SRC_PRODUCT; dlen = cfg.product_desc_length; end
                8'd3: begin src = SRC_SERIAL; dlen = SERIAL_LEN; end
                default: ;
              endcase
            end
            default: cmd.stall = 1'b1;
          endcase
          total = (req.length_word > {8'd0, dlen}) ? dlen : req.length_word[7:0];
          len = (total > {1'b0, ep}) ? {1'b0, ep} : total;
          cmd.remaining = {8'd0, total - len};
          cmd.desc_wr = ~cmd.stall;
          cmd.src = src;
          cmd.offset = len;
        end
        RC_SET_ADDRESS: cmd.remaining = {8'd0, req.value_word[7:0]};
        RC_GET_CONFIG: begin
          len = (req.length_word != 16'd0) ? 8'd1 : 8'd0;
          src = SRC_CFGBYTE;
        end
        RC_SET_CONFIG: begin
          cmd.cfg_wr = 1'b1;
          cmd.cfg_val = req.value_word[7:0];
        end
        RC_GET_IFACE, RC_SET_IFACE: ;
        RC_CLR_FEATURE, RC_SET_FEATURE: begin
          if (req.request_type[4:0] == 5'd0) begin
            if (req.value_word == 16'h0001 && cfg.wakeup_capable)
              cmd.ev_sleep = (req.request_code == RC_SET_FEATURE);
            else cmd.stall = 1'b1;
          end else if (req.request_type[4:0] == 5'd2) begin
            sel = (req.request_code == RC_CLR_FEATURE) ?
                  ep_select({8'd0, req.index_word[7:0]}) : ep_select(req.index_word);
            if (sel == 4'd0 ||
                (req.request_code == RC_SET_FEATURE && req.value_word != 16'd0)) begin
              cmd.stall = 1'b1;
            end else begin
              cmd.ev_sel = sel;
              cmd.ev_act = (req.request_code == RC_CLR_FEATURE) ? ACT_CLEAR : ACT_HALT;
            end
          end else begin
            cmd.stall = 1'b1;
          end
        end
        RC_GET_STATUS: begin
          len = (req.length_word >= 16'd2) ? 8'd2 : req.length_word[7:0];
          src = SRC_ZEROS;
        end
        default: cmd.stall = 1'b1;
      endcase
    end
    // reply longer than a chunk goes out as an empty packet
    cmd.pkt_len = (len <= {1'b0, ep}) ? len[6:0] : 7'd0;
    cmd.pkt_src = (cmd.pkt_len != 7'd0) ? src : SRC_NONE;
    if (cmd.stall) begin
      cmd.pending = NO_REQUEST;
      cmd.desc_wr = 1'b0;
      cmd.cfg_wr = 1'b0;
      cmd.pkt_len = 7'd0;
      cmd.pkt_src = SRC_NONE;
      cmd.ev_class = EV_NONE;
      cmd.ev_sel = 4'd0;
      cmd.ev_act = ACT_NONE;
      cmd.ev_sleep = 1'b0;
    end
  end

endmodule

FILE: design/usbep_queue.sv
// Short command queue between front and back
module usbep_queue import usbep_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);
  `include "assert_macros.svh"

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `USBEP_NEVER(a_count_range, clk, rst, count > CW'(DEPTH))
  `USBEP_NEVER(a_pop_empty, clk, rst, pop && !head_valid)
  `USBEP_ASSERT(a_pop_drains, clk, rst, (pop && !push) |=> (count == $past(count) - 1'b1))

endmodule

FILE: design/usbep_back.sv
// Back part: endpoint state, token handling and registered results
module usbep_back import usbep_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic head_valid,
  input  cmd_t head_cmd,
  output logic pop,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic [15:0] remaining_length, remaining_length_next;
  logic [7:0]  pending_request, pending_request_next;
  logic [3:0]  current_source, current_source_next;
  logic [7:0]  current_offset, current_offset_next;
  logic [6:0]  active_address, active_address_next;
  logic [7:0]  selected_config, selected_config_next;
  logic        in_toggle, in_toggle_next;
  logic [1:0]  in_hs, in_hs_next, out_hs, out_hs_next;
  logic [6:0]  pkt_len, pkt_len_next;
  logic [3:0]  pkt_src, pkt_src_next;
  logic [7:0]  pkt_off, pkt_off_next;
  logic [1:0]  ev_class;
  logic [6:0]  ep, chunk;
  logic        live;
  rsp_t        rsp_next;

  assign pop   = head_valid & (~rsp_valid | ~rsp_stall);
  assign ep    = chunk_size(cfg.ep0_packet_size);
  assign chunk = (remaining_length > {9'd0, ep}) ? ep : remaining_length[6:0];

  // next state for one command
  always_comb begin
    remaining_length_next = remaining_length;
    pending_request_next  = pending_request;
    current_source_next   = current_source;
    current_offset_next   = current_offset;
    active_address_next   = active_address;
    selected_config_next  = selected_config;
    in_toggle_next        = in_toggle;
    in_hs_next            = in_hs;
    out_hs_next           = out_hs;
    pkt_len_next          = pkt_len;
    pkt_src_next          = pkt_src;
    pkt_off_next          = pkt_off;
    ev_class              = EV_NONE;
    unique case (head_cmd.op)
      OP_SETUP: begin
        in_toggle_next       = 1'b1;
        pending_request_next = head_cmd.pending;
        if (head_cmd.len_ok) remaining_length_next = head_cmd.remaining;
        if (head_cmd.desc_wr) begin
          current_source_next = head_cmd.src;
          current_offset_next = head_cmd.offset;
        end
        if (head_cmd.cfg_wr) selected_config_next = head_cmd.cfg_val;
        in_hs_next   = head_cmd.stall ? HS_STALL : HS_ACK;
        out_hs_next  = head_cmd.stall ? HS_STALL : HS_ACK;
        pkt_len_next = head_cmd.pkt_len;
        pkt_src_next = head_cmd.pkt_src;
        pkt_off_next = 8'd0;
        ev_class     = head_cmd.ev_class;
      end
      OP_IN: begin
        if (in_hs == HS_ACK) begin
          if (pending_request == RC_GET_DESC) begin
            // next chunk of a descriptor
            pkt_len_next = chunk;
            pkt_src_next = (chunk != 7'd0) ? current_source : SRC_NONE;
            pkt_off_next = (chunk != 7'd0) ? current_offset : 8'd0;
            current_offset_next   = current_offset + {1'b0, chunk};
            remaining_length_next = remaining_length - {9'd0, chunk};
            in_toggle_next = ~in_toggle;
          end else begin
            // status stage done
            if (pending_request == RC_SET_ADDRESS)
              active_address_next = remaining_length[6:0];
            in_hs_next     = HS_NAK;
            out_hs_next    = HS_ACK;
            in_toggle_next = 1'b0;
            pkt_len_next   = 7'd0;
            pkt_src_next   = SRC_NONE;
            pkt_off_next   = 8'd0;
          end
        end
      end
      OP_OUT: begin
        if (out_hs == HS_ACK) begin
          if (pending_request == RC_SEND_ENCAP) begin
            if (head_cmd.toggle_matched) begin
              ev_class     = EV_CODING_DAT;
              pkt_len_next = 7'd0;
              pkt_src_next = SRC_NONE;
              pkt_off_next = 8'd0;
            end
          end else begin
            if (in_hs == HS_ACK) in_hs_next = HS_NAK;
            pkt_len_next = 7'd0;
            pkt_src_next = SRC_NONE;
            pkt_off_next = 8'd0;
          end
        end
      end
      OP_RESET: begin
        in_hs_next           = HS_NAK;
        out_hs_next          = HS_ACK;
        in_toggle_next       = 1'b0;
        active_address_next  = 7'd0;
        selected_config_next = 8'd0;
        pkt_len_next         = 7'd0;
        pkt_src_next         = SRC_NONE;
        pkt_off_next         = 8'd0;
      end
      default: ;
    endcase
  end

  // result assembly
  always_comb begin
    live = (in_hs_next == HS_ACK);
    rsp_next.in_handshake    = in_hs_next;
    rsp_next.out_handshake   = out_hs_next;
    rsp_next.data_toggle     = in_toggle_next;
    rsp_next.send_length     = live ? pkt_len_next : 7'd0;
    rsp_next.data_source     = live ? pkt_src_next : SRC_NONE;
    rsp_next.source_offset   = live ? pkt_off_next : 8'd0;
    rsp_next.device_address  = active_address_next;
    rsp_next.config_value    = selected_config_next;
    rsp_next.class_event     = ev_class;
    rsp_next.endpoint_select = (head_cmd.op == OP_SETUP) ? head_cmd.ev_sel : 4'd0;
    rsp_next.endpoint_action = (head_cmd.op == OP_SETUP) ? head_cmd.ev_act : ACT_NONE;
    rsp_next.sleep_request   = (head_cmd.op == OP_SETUP) & head_cmd.ev_sleep;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining_length <= 16'd0;
      pending_request  <= NO_REQUEST;
      current_source   <= SRC_NONE;
      current_offset   <= 8'd0;
      active_address   <= 7'd0;
      selected_config  <= 8'd0;
      in_toggle        <= 1'b0;
      in_hs            <= HS_NAK;
      out_hs           <= HS_ACK;
      pkt_len          <= 7'd0;
      pkt_src          <= SRC_NONE;
      pkt_off          <= 8'd0;
    end else if (pop) begin
      remaining_length <= remaining_length_next;
      pending_request  <= pending_request_next;
      current_source   <= current_source_next;
      current_offset   <= current_offset_next;
      active_address   <= active_address_next;
      selected_config  <= selected_config_next;
      in_toggle        <= in_toggle_next;
      in_hs            <= in_hs_next;
      out_hs           <= out_hs_next;
      pkt_len          <= pkt_len_next;
      pkt_src          <= pkt_src_next;
      pkt_off          <= pkt_off_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) rsp <= rsp_next;
  end

endmodule

FILE: design/usb_control_endpoint_requests_core.sv
// Top level of the USB control endpoint request engine
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    req_t  (setup, IN, OUT, bus reset)
//  rsp      out        rsp_valid/stall    rsp_t  (handshakes, next IN packet)
//  apb      in/out     psel/penable       8 length and option registers
//
// One request per cycle sustained while results are not stalled; an accepted
// request is written into a queue slot, then taken into the result register.
// The back part applies one command per cycle while its result is not stalled,
// so its state loop sets the rate. Reset is synchronous and clears the queue,
// endpoint state and registers. A stalled result holds the back part; the queue then fills and stalls req.
module usb_control_endpoint_requests_core import usbep_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  logic push, full, head_valid, pop;
  cmd_t push_cmd, head_cmd;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_desc_length   <= 8'd18;
      cfg.config_desc_length   <= 8'd9;
      cfg.language_desc_length <= 8'd4;
      cfg.maker_desc_length    <= 8'd0;
      cfg.product_desc_length  <= 8'd0;
      cfg.wakeup_capable       <= 1'b0;
      cfg.ep0_packet_size      <= 7'd8;
      cfg.line_coding_length   <= 7'd7;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_DEVICE_LEN:  cfg.device_desc_length   <= pwdata[7:0];
        REG_CONFIG_LEN:  cfg.config_desc_length   <= pwdata[7:0];
        REG_LANG_LEN:    cfg.language_desc_length <= pwdata[7:0];
        REG_MAKER_LEN:   cfg.maker_desc_length    <= pwdata[7:0];
        REG_PRODUCT_LEN: cfg.product_desc_length  <= pwdata[7:0];
        REG_WAKEUP:      cfg.wakeup_capable       <= pwdata[0];
        REG_EP0_SIZE:    cfg.ep0_packet_size      <= pwdata[6:0];
        REG_CODING_LEN:  cfg.line_coding_length   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_DEVICE_LEN:  prdata = {24'd0, cfg.device_desc_length};
      REG_CONFIG_LEN:  prdata = {24'd0, cfg.config_desc_length};
      REG_LANG_LEN:    prdata = {24'd0, cfg.language_desc_length};
      REG_MAKER_LEN:   prdata = {24'd0, cfg.maker_desc_length};
      REG_PRODUCT_LEN: prdata = {24'd0, cfg.product_desc_length};
      REG_WAKEUP:      prdata = {31'd0, cfg.wakeup_capable};
      REG_EP0_SIZE:    prdata = {25'd0, cfg.ep0_packet_size};
      REG_CODING_LEN:  prdata = {25'd0, cfg.line_coding_length};
      default:         prdata = 32'd0;
    endcase
  end

  usbep_front u_front (
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full)
  );

  usbep_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  usbep_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

FILE: tb/ep0_answer_checker.sv
// Checker for the endpoint-0 engine: predicts each answer from requests and compares
`timescale 1ns / 100ps

module ep0_answer_checker import usbep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          answers_owed,
  output int          mismatches
);

  // register copy, taken from writes seen on the configuration port
  cfg_t        regs;
  // endpoint state as the block should hold it
  logic [15:0] remaining;
  logic [7:0]  pending;
  logic [3:0]  cur_src;
  logic [7:0]  cur_off;
  logic [6:0]  bus_addr;
  logic [7:0]  conf_sel;
  logic        toggle;
  logic [1:0]  in_hs;
  logic [1:0]  out_hs;
  logic [6:0]  pkt_len;
  logic [3:0]  pkt_src;
  logic [7:0]  pkt_off;

  rsp_t answers_due[$];

  // endpoint address to select code; zero unless endpoint 1..4
  function automatic logic [3:0] endpoint_code(input logic [15:0] epa);
    logic [6:0] n;
    n = epa[6:0];
    if (epa > 16'h00FF || n < 7'd1 || n > 7'd4) return 4'd0;
    return epa[7] ? 4'(n + 4) : 4'(n);
  endfunction

  task automatic clear_packet();
    pkt_len = '0;
    pkt_src = SRC_NONE;
    pkt_off = '0;
  endtask

  // advance the predicted endpoint by one request and form its answer
  task automatic apply_request(input req_t r, output rsp_t a);
    int         ep;
    int         len;
    int         dlen;
    int         total;
    int         c;
    logic [3:0] src;
    logic       stall;
    logic [1:0] ev_class;
    logic [3:0] ev_sel;
    logic [1:0] ev_act;
    logic       ev_sleep;
    logic [3:0] sel;
    logic       live;
    ep = (regs.ep0_packet_size > MAX_CHUNK) ? int'(MAX_CHUNK) : int'(regs.ep0_packet_size);
    len = 0;
    dlen = 0;
    src = SRC_NONE;
    stall = 1'b0;
    ev_class = EV_NONE;
    ev_sel = '0;
    ev_act = ACT_NONE;
    ev_sleep = 1'b0;
    case (opcode_t'(r.opcode))
      OP_SETUP: begin
        if (r.received_length != SETUP_BYTES) begin
          stall = 1'b1;
        end else begin
          remaining = r.length_word;
          pending = r.request_code;
          if (r.request_type[6:5] == 2'b01) begin
            // class requests
            case (r.request_code)
              RC_GET_CODING: begin
                len = regs.line_coding_length;
                ev_class = EV_GET_CODING;
              end
              RC_SET_LINES:  ev_class = EV_SET_LINES;
              RC_SEND_ENCAP: ;
              default:       stall = 1'b1;
            endcase
          end else if (r.request_type[6:5] != 2'b00) begin
            stall = 1'b1;
          end else begin
            case (r.request_code)
              RC_GET_DESC: begin
                case (r.value_word[15:8])
                  8'd1: begin src = SRC_DEVICE; dlen = regs.device_desc_length; end
                  8'd2: begin src = SRC_CONFIG; dlen = regs.config_desc_length; end
                  8'd3: begin
                    // unknown string index gives an empty data stage
                    case (r.value_word[7:0])
                      8'd0: begin src = SRC_LANG; dlen = regs.language_desc_length; end
                      8'd1: begin src = SRC_MAKER; dlen = regs.maker_desc_length; end
                      8'd2: begin src = SRC_PRODUCT; dlen = regs.product_desc_length; end
                      8'd3: begin src = SRC_SERIAL; dlen = SERIAL_LEN; end
                      default: ;
                    endcase
                  end
                  default: stall = 1'b1;
                endcase
                if (!stall) begin
                  total = (r.length_word > dlen) ? dlen : r.length_word;
                  len = (total > ep) ? ep : total;
                  remaining = 16'(total - len);
                  cur_src = src;
                  cur_off = 8'(len);
                end
              end
              RC_SET_ADDRESS: remaining = {8'h00, r.value_word[7:0]};
              RC_GET_CONFIG: begin
                len = (r.length_word >= 1) ? 1 : 0;
                src = SRC_CFGBYTE;
              end
              RC_SET_CONFIG: conf_sel = r.value_word[7:0];
              RC_GET_IFACE, RC_SET_IFACE: ;
              RC_CLR_FEATURE, RC_SET_FEATURE: begin
                if (r.request_type[4:0] == 5'd0) begin
                  if (r.value_word == 16'h0001 && regs.wakeup_capable) begin
                    if (r.request_code == RC_SET_FEATURE) ev_sleep = 1'b1;
                  end else begin
                    stall = 1'b1;
                  end
                end else if (r.request_type[4:0] == 5'd2) begin
                  sel = (r.request_code == RC_CLR_FEATURE) ?
                        endpoint_code({8'h00, r.index_word[7:0]}) : endpoint_code(r.index_word);
                  if (sel == 4'd0 || (r.request_code == RC_SET_FEATURE && r.value_word != 0)) begin
                    stall = 1'b1;
                  end else begin
                    ev_sel = sel;
                    ev_act = (r.request_code == RC_CLR_FEATURE) ? ACT_CLEAR : ACT_HALT;
                  end
                end else begin
                  stall = 1'b1;
                end
              end
              RC_GET_STATUS: begin
                len = (r.length_word >= 2) ? 2 : r.length_word;
                src = SRC_ZEROS;
              end
              default: stall = 1'b1;
            endcase
          end
        end
        toggle = 1'b1;
        if (stall) begin
          pending = NO_REQUEST;
          in_hs = HS_STALL;
          out_hs = HS_STALL;
          clear_packet();
        end else begin
          in_hs = HS_ACK;
          out_hs = HS_ACK;
          // a reply longer than one chunk goes out as an empty packet
          pkt_len = (len <= ep) ? 7'(len) : 7'd0;
          pkt_src = (pkt_len != 0) ? src : SRC_NONE;
          pkt_off = '0;
        end
      end
      OP_IN: begin
        if (in_hs == HS_ACK) begin
          if (pending == RC_GET_DESC) begin
            c = (remaining > ep) ? ep : remaining;
            pkt_len = 7'(c);
            pkt_src = (c != 0) ? cur_src : SRC_NONE;
            pkt_off = (c != 0) ? cur_off : 8'd0;
            cur_off = 8'(cur_off + c);
            remaining = 16'(remaining - c);
            toggle = ~toggle;
          end else begin
            if (pending == RC_SET_ADDRESS) bus_addr = remaining[6:0];
            in_hs = HS_NAK;
            out_hs = HS_ACK;
            toggle = 1'b0;
            clear_packet();
          end
        end
      end
      OP_OUT: begin
        if (out_hs == HS_ACK) begin
          if (pending == RC_SEND_ENCAP) begin
            if (r.toggle_matched) begin
              ev_class = EV_CODING_DAT;
              clear_packet();
            end
          end else begin
            // status stage
            if (in_hs == HS_ACK) in_hs = HS_NAK;
            clear_packet();
          end
        end
      end
      default: begin
        // bus reset keeps the pending request
        in_hs = HS_NAK;
        out_hs = HS_ACK;
        toggle = 1'b0;
        bus_addr = '0;
        conf_sel = '0;
        clear_packet();
      end
    endcase
    live = (in_hs == HS_ACK);
    a.in_handshake = in_hs;
    a.out_handshake = out_hs;
    a.data_toggle = toggle;
    a.send_length = live ? pkt_len : 7'd0;
    a.data_source = live ? pkt_src : SRC_NONE;
    a.source_offset = live ? pkt_off : 8'd0;
    a.device_address = bus_addr;
    a.config_value = conf_sel;
    a.class_event = ev_class;
    a.endpoint_select = ev_sel;
    a.endpoint_action = ev_act;
    a.sleep_request = ev_sleep;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // watch the channels on every rising edge
  always @(posedge clk) begin
    rsp_t a;
    rsp_t want;
    if (rst) begin
      regs = '{device_desc_length: 8'd18, config_desc_length: 8'd9,
               language_desc_length: 8'd4, maker_desc_length: 8'd0,
               product_desc_length: 8'd0, wakeup_capable: 1'b0,
               ep0_packet_size: 7'd8, line_coding_length: 7'd7};
      remaining = '0;
      pending = NO_REQUEST;
      cur_src = SRC_NONE;
      cur_off = '0;
      bus_addr = '0;
      conf_sel = '0;
      toggle = 1'b0;
      in_hs = HS_NAK;
      out_hs = HS_ACK;
      clear_packet();
      answers_due.delete();
      mismatches = 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_DEVICE_LEN:  regs.device_desc_length = pwdata[7:0];
          REG_CONFIG_LEN:  regs.config_desc_length = pwdata[7:0];
          REG_LANG_LEN:    regs.language_desc_length = pwdata[7:0];
          REG_MAKER_LEN:   regs.maker_desc_length = pwdata[7:0];
          REG_PRODUCT_LEN: regs.product_desc_length = pwdata[7:0];
          REG_WAKEUP:      regs.wakeup_capable = pwdata[0];
          REG_EP0_SIZE:    regs.ep0_packet_size = pwdata[6:0];
          default:         regs.line_coding_length = pwdata[6:0];
        endcase
      end
      // answers leaving the block
      if (rsp_valid && !rsp_stall) begin
        if (answers_due.size() == 0) begin
          $error("answer with no request outstanding");
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          check_field("in_handshake", want.in_handshake, rsp.in_handshake);
          check_field("out_handshake", want.out_handshake, rsp.out_handshake);
          check_field("data_toggle", want.data_toggle, rsp.data_toggle);
          check_field("send_length", want.send_length, rsp.send_length);
          check_field("data_source", want.data_source, rsp.data_source);
          check_field("source_offset", want.source_offset, rsp.source_offset);
          check_field("device_address", want.device_address, rsp.device_address);
          check_field("config_value", want.config_value, rsp.config_value);
          check_field("class_event", want.class_event, rsp.class_event);
          check_field("endpoint_select", want.endpoint_select, rsp.endpoint_select);
          check_field("endpoint_action", want.endpoint_action, rsp.endpoint_action);
          check_field("sleep_request", want.sleep_request, rsp.sleep_request);
        end
      end
      // requests entering the block
      if (req_valid && !req_stall) begin
        apply_request(req, a);
        answers_due.push_back(a);
      end
    end
    answers_owed <= answers_due.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the endpoint-0 engine testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module testbench;
  import usbep_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int ReqBits = $bits(req_t);

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int answers_owed;
  int mismatches;
  int cycles;
  bit calm;
  bit hold_off;

  usb_control_endpoint_requests_core uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ep0_answer_checker checker_i (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .answers_owed(answers_owed), .mismatches(mismatches)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** usb_control_endpoint_requests_core: FAILED **");
      $finish;
    end
  end

  // receiver side: random stalls, one long hold-off on request
  initial begin
    int n;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        rsp_stall <= 1'b1;
        repeat (120) @(negedge clk);
        rsp_stall <= 1'b0;
        hold_off = 1'b0;
      end else if (calm) begin
        rsp_stall <= 1'b0;
      end else begin
        n = $urandom_range(0, 99);
        if (n < 65) begin
          rsp_stall <= 1'b0;
        end else begin
          rsp_stall <= 1'b1;
          if (n < 95) repeat ($urandom_range(0, 3)) @(negedge clk);
          else repeat ($urandom_range(10, 40)) @(negedge clk);
        end
      end
    end
  end

  function automatic int sender_gap();
    int n;
    if (calm) return 0;
    n = $urandom_range(0, 99);
    if (n < 60) return 0;
    if (n < 90) return $urandom_range(1, 3);
    if (n < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // offer one request and wait until it is taken
  task automatic send(input req_t r);
    int  gap;
    bit  taken;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    forever begin
      #1 taken = !req_stall;
      @(posedge clk);
      if (taken) break;
      @(negedge clk);
    end
  endtask

  task automatic go_quiet();
    @(negedge clk);
    req_valid <= 1'b0;
  endtask

  // wait until every answer is in, then let the pipeline settle
  task automatic drain();
    go_quiet();
    while (answers_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] index, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_all(input logic [7:0] dev, input logic [7:0] cfg,
                           input logic [7:0] lang, input logic [7:0] maker,
                           input logic [7:0] prod, input logic wake,
                           input logic [6:0] ep, input logic [6:0] coding);
    reg_write(REG_DEVICE_LEN, 32'(dev));
    reg_write(REG_CONFIG_LEN, 32'(cfg));
    reg_write(REG_LANG_LEN, 32'(lang));
    reg_write(REG_MAKER_LEN, 32'(maker));
    reg_write(REG_PRODUCT_LEN, 32'(prod));
    reg_write(REG_WAKEUP, 32'(wake));
    reg_write(REG_EP0_SIZE, 32'(ep));
    reg_write(REG_CODING_LEN, 32'(coding));
  endtask

  function automatic req_t setup_req(input logic [7:0] rt, input logic [7:0] rc,
                                     input logic [15:0] wv, input logic [15:0] wi,
                                     input logic [15:0] wl);
    req_t r;
    r.opcode = OP_SETUP;
    r.received_length = SETUP_BYTES;
    r.request_type = rt;
    r.request_code = rc;
    r.value_word = wv;
    r.index_word = wi;
    r.length_word = wl;
    r.toggle_matched = 1'($urandom);
    return r;
  endfunction

  // token with random don't-care fields
  function automatic req_t token(input opcode_t op, input logic tm);
    req_t r;
    r = req_t'(ReqBits'({$urandom, $urandom, $urandom}));
    r.opcode = op;
    r.toggle_matched = tm;
    return r;
  endfunction

  function automatic logic [15:0] rand_length();
    int n;
    n = $urandom_range(0, 9);
    if (n < 5) return 16'($urandom_range(0, 80));
    if (n < 7) return 16'($urandom_range(0, 300));
    if (n < 8) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // well-formed setup with random content
  function automatic req_t random_setup();
    logic [7:0]  rt;
    logic [15:0] wv;
    logic [15:0] wi;
    rt = {1'($urandom), 2'b00, 5'd0};
    wi = 16'($urandom);
    case ($urandom_range(0, 13))
      0, 1, 2: begin
        wv = {8'($urandom_range(1, 3)), 8'($urandom_range(0, 5))};
        if ($urandom_range(0, 9) == 0) wv = 16'($urandom);
        return setup_req(8'h80, RC_GET_DESC, wv, wi, rand_length());
      end
      3:  return setup_req(8'h00, RC_SET_ADDRESS, 16'($urandom), wi, 16'd0);
      4:  return setup_req(8'h80, RC_GET_CONFIG, 16'($urandom), wi, rand_length());
      5:  return setup_req(8'h00, RC_SET_CONFIG, 16'($urandom), wi, 16'd0);
      6:  return setup_req(rt, $urandom_range(0, 1) ? RC_GET_IFACE : RC_SET_IFACE,
                           16'($urandom), wi, rand_length());
      7:  return setup_req({rt[7], 2'b00, 5'($urandom_range(0, 3))}, RC_GET_STATUS,
                           16'($urandom), wi, 16'($urandom_range(0, 4)));
      8, 9: begin
        rt = {1'b0, 2'b00, $urandom_range(0, 1) ? 5'd2 : 5'($urandom_range(0, 31))};
        wv = $urandom_range(0, 2) ? 16'(rt[1] ? 0 : 1) : 16'($urandom);
        wi = $urandom_range(0, 2) ?
             {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00,
              1'($urandom), 7'($urandom_range(0, 5))} : 16'($urandom);
        return setup_req(rt, $urandom_range(0, 1) ? RC_CLR_FEATURE : RC_SET_FEATURE,
                         wv, wi, 16'd0);
      end
      10, 11: begin
        rt = {1'($urandom), 2'b01, 5'($urandom)};
        return setup_req(rt, 8'($urandom_range(RC_SEND_ENCAP, RC_SET_LINES + 1)),
                         16'($urandom), wi, rand_length());
      end
      12: return setup_req({1'($urandom), 2'($urandom_range(2, 3)), 5'($urandom)},
                           8'($urandom), 16'($urandom), wi, rand_length());
      default: return setup_req(8'($urandom), 8'($urandom), 16'($urandom), wi,
                                16'($urandom));
    endcase
  endfunction

  // mostly control transfers, with bus resets and noise mixed in
  task automatic random_phase(input int count);
    int sent;
    int k;
    req_t r;
    sent = 0;
    while (sent < count) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        send(random_setup());
        sent++;
        repeat ($urandom_range(0, 6)) begin
          send(token(OP_IN, 1'($urandom)));
          sent++;
        end
        if ($urandom_range(0, 9) < 7) begin
          send(token(OP_OUT, 1'($urandom)));
          sent++;
        end
      end else if (k == 7) begin
        send(token(OP_RESET, 1'($urandom)));
        sent++;
      end else begin
        r = req_t'(ReqBits'({$urandom, $urandom, $urandom}));
        r.received_length = $urandom_range(0, 3) ? 7'($urandom_range(0, 64)) : SETUP_BYTES;
        send(r);
        sent++;
      end
    end
  endtask

  initial begin
    req_t r;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    hold_off = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part on reset settings
    send(token(OP_IN, 1'b1));                                   // IN while nak
    send(setup_req(8'h80, RC_GET_DESC, 16'h0100, 16'h0000, 16'd64));
    repeat (3) send(token(OP_IN, 1'b1));
    send(token(OP_OUT, 1'b0));                                  // status stage
    send(setup_req(8'h00, RC_SET_ADDRESS, 16'h00FF, 16'hFFFF, 16'd0));
    send(token(OP_IN, 1'b0));
    r = setup_req(8'h80, RC_GET_DESC, 16'h0100, 16'h0000, 16'd64);
    r.received_length = 7'd64;                                  // bad setup length
    send(r);
    send(token(OP_IN, 1'b1));
    send(setup_req(8'h80, RC_GET_DESC, 16'h0305, 16'h0409, 16'hFFFF));  // unknown string
    send(setup_req(8'h80, RC_GET_DESC, 16'h0303, 16'h0409, 16'hFFFF));  // serial
    repeat (3) send(token(OP_IN, 1'b0));
    send(setup_req(8'h00, RC_SET_FEATURE, 16'h0001, 16'h0000, 16'd0));  // wakeup refused
    send(setup_req(8'h02, RC_CLR_FEATURE, 16'h0000, 16'hFF81, 16'd0));
    send(setup_req(8'h02, RC_SET_FEATURE, 16'h0000, 16'h0184, 16'd0));
    send(setup_req(8'h21, RC_SEND_ENCAP, 16'hFFFF, 16'hFFFF, 16'd7));
    send(token(OP_OUT, 1'b0));
    send(token(OP_OUT, 1'b1));
    send(setup_req(8'h00, RC_SET_CONFIG, 16'hFFFF, 16'h0000, 16'd0));
    send(setup_req(8'h80, RC_GET_CONFIG, 16'h0000, 16'h0000, 16'd1));
    send(setup_req(8'h80, RC_GET_STATUS, 16'h0000, 16'h0000, 16'd2));
    send(setup_req(8'hC0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));       // vendor
    send(token(OP_RESET, 1'b1));
    drain();

    // lower extremes; line coding reply longer than a chunk
    write_all(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 7'd8, 7'd64);
    send(setup_req(8'hA1, RC_GET_CODING, 16'h0000, 16'h0000, 16'd64));
    send(setup_req(8'h00, RC_SET_FEATURE, 16'h0001, 16'h0000, 16'd0));
    send(setup_req(8'h21, RC_SET_LINES, 16'h0003, 16'h0000, 16'd0));
    random_phase(110);
    drain();

    // upper extremes, no stalls or gaps
    calm = 1'b1;
    write_all(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 7'd64, 7'd0);
    random_phase(110);
    calm = 1'b0;
    drain();

    // random settings; each one carries a long receiver hold-off
    repeat (3) begin
      write_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom), 7'($urandom_range(8, 64)), 7'($urandom_range(0, 64)));
      random_phase(40);
      if (!hold_off && cycles > 0) begin
        hold_off = 1'b1;
        random_phase(20);
        drain();
      end
      random_phase(70);
      drain();
    end

    while (answers_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("** usb_control_endpoint_requests_core: PASSED **");
    else
      $display("** usb_control_endpoint_requests_core: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/usbep_pkg.sv
design/usbep_front.sv
design/usbep_queue.sv
design/usbep_back.sv
design/usb_control_endpoint_requests_core.sv
tb/ep0_answer_checker.sv
tb/testbench.sv
